### rtl/core/cdg_pkg.sv
// Shared types, sizes and helpers for the central-difference gradient unit.
// No dependencies; every other file in rtl/core imports this package.
package cdg_pkg;

  // Frame limits and the widths that follow from them
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);

  // Configuration port
  localparam int CFG_WIDTH_BITS  = 12;
  localparam int CFG_HEIGHT_BITS = 13;
  localparam int CFG_DATA_W      = 13;
  localparam int CFG_IDX_W       = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Pixel and gradient formats
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int GRAD_W = CHAN_W + 1;
  localparam int OUT_FIELDS_W = ROW_W + COL_W + 6 * GRAD_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] red;
    logic signed [GRAD_W-1:0] green;
    logic signed [GRAD_W-1:0] blue;
  } grad3_t;

  typedef struct packed {
    logic [WID_W-1:0] image_width;
    logic [HGT_W-1:0] image_height;
    logic             restart;
  } dim_cfg_t;

  // One queue entry: up to three results raised by one pixel.
  // a: pixel above (row-1, col); b: left neighbour on the last row (row, col-1);
  // c: the frame's final pixel itself.
  typedef struct packed {
    logic             has_a;
    logic             has_b;
    logic             has_c;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    grad3_t           gx_a;
    grad3_t           gy_a;
    grad3_t           gx_b;
  } q_entry_t;

  typedef struct packed {
    logic              not_empty;
    logic [QCNT_W-1:0] level;
  } q_stat_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    grad3_t           gx;
    grad3_t           gy;
    logic             last;
    logic             eof;
  } result_t;

  function automatic grad3_t pix_diff(input pix_t a, input pix_t b);
    grad3_t d;
    d.blue  = $signed({1'b0, a.blue})  - $signed({1'b0, b.blue});
    d.green = $signed({1'b0, a.green}) - $signed({1'b0, b.green});
    d.red   = $signed({1'b0, a.red})   - $signed({1'b0, b.red});
    return d;
  endfunction

  function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_WIDTH_BITS-1:0] v);
    logic [WID_W-1:0] r;
    if (v == '0) r = WID_W'(1);
    else if (32'(v) > MAX_WIDTH) r = WID_W'(MAX_WIDTH);
    else r = WID_W'(v);
    return r;
  endfunction

  function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_HEIGHT_BITS-1:0] v);
    logic [HGT_W-1:0] r;
    if (v == '0) r = HGT_W'(1);
    else if (32'(v) > MAX_HEIGHT) r = HGT_W'(MAX_HEIGHT);
    else r = HGT_W'(v);
    return r;
  endfunction

endpackage

### rtl/core/cdg_front.sv
// Front end: pixel intake, raster counters, ping-pong line stores and the
// difference stage that fills at most one queue entry per pixel. Uses cdg_pkg.
module cdg_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cdg_pkg::dim_cfg_t       dim,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  cdg_pkg::pix_t           in_pix,
  input  cdg_pkg::q_stat_t        q_stat,
  output logic                    q_push,
  output cdg_pkg::q_entry_t       q_entry
);
  import cdg_pkg::*;

  logic             in_acc;
  logic [COL_W-1:0] col_r, col_nxt, col_up;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             row_end, last_row;
  logic [QCNT_W-1:0] in_flight;

  // Line stores: a row goes to bank row[0], so the other bank holds the row
  // above and this bank still holds the row two above until overwritten.
  pix_t bank0 [MAX_WIDTH];
  pix_t bank1 [MAX_WIDTH];
  pix_t b0_rd0_r, b0_rd1_r, b1_rd0_r, b1_rd1_r;

  logic             s1_v_r;
  pix_t             s1_px_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_odd_r, s1_has_a_r, s1_hx_a_r, s1_hy_a_r;
  logic             s1_has_b_r, s1_hx_b_r, s1_has_c_r;

  pix_t above_left_r, left1_r, left2_r;
  pix_t newer_c, newer_right, older_c;

  // Room for this beat and the one in the difference stage
  assign in_flight = q_stat.level + QCNT_W'(s1_v_r);
  assign in_tready = (in_flight < QCNT_W'(Q_DEPTH));
  assign in_acc    = in_tvalid && in_tready;

  assign row_end  = (WID_W'(col_r) == dim.image_width - WID_W'(1));
  assign last_row = (HGT_W'(row_r) == dim.image_height - HGT_W'(1));
  assign col_up   = col_r + COL_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || dim.restart) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!row_r[0]) bank0[col_r] <= in_pix;
      b0_rd0_r <= bank0[col_r];
      b0_rd1_r <= bank0[col_up];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (row_r[0]) bank1[col_r] <= in_pix;
      b1_rd0_r <= bank1[col_r];
      b1_rd1_r <= bank1[col_up];
    end
  end

  // Classify the pixel on intake
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= in_acc;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r    <= in_pix;
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
      s1_odd_r   <= row_r[0];
      s1_has_a_r <= (row_r != '0);
      s1_hx_a_r  <= (col_r != '0) && !row_end;
      s1_hy_a_r  <= (row_r != ROW_W'(1));
      s1_has_b_r <= last_row && (col_r != '0);
      s1_hx_b_r  <= (col_r != COL_W'(1));
      s1_has_c_r <= last_row && row_end;
    end
  end

  // Select the rows by parity of the current row
  assign newer_c     = s1_odd_r ? b0_rd0_r : b1_rd0_r;
  assign newer_right = s1_odd_r ? b0_rd1_r : b1_rd1_r;
  assign older_c     = s1_odd_r ? b1_rd0_r : b0_rd0_r;

  // Advance the window once per pixel
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      above_left_r <= newer_c;
      left2_r      <= left1_r;
      left1_r      <= s1_px_r;
    end
  end

  always_comb begin
    q_entry.has_a = s1_has_a_r;
    q_entry.has_b = s1_has_b_r;
    q_entry.has_c = s1_has_c_r;
    q_entry.row   = s1_row_r;
    q_entry.col   = s1_col_r;
    q_entry.gx_a  = s1_hx_a_r ? pix_diff(newer_right, above_left_r) : '0;
    q_entry.gy_a  = s1_hy_a_r ? pix_diff(s1_px_r, older_c) : '0;
    q_entry.gx_b  = s1_hx_b_r ? pix_diff(s1_px_r, left2_r) : '0;
  end

  assign q_push = s1_v_r && (s1_has_a_r || s1_has_b_r || s1_has_c_r);

  // The frame's last pixel also closes its own row on the left, unless alone
  a_last_needs_left: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_has_c_r |-> s1_has_b_r || (s1_col_r == '0))
    else $error("final-pixel result without its left neighbour result");

endmodule

### rtl/core/cdg_queue.sv
// Short queue of per-pixel result entries between front and back.
// Uses cdg_pkg for the entry type and depth.
module cdg_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cdg_pkg::q_entry_t    push_entry,
  input  logic                 pop,
  output cdg_pkg::q_entry_t    head,
  output cdg_pkg::q_stat_t     stat
);
  import cdg_pkg::*;

  q_entry_t          slot_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + QCNT_W'(1);
    else if (pop && !push) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  assign head           = slot_r[rd_ptr_r];
  assign stat.not_empty = (count_r != '0);
  assign stat.level     = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r != QCNT_W'(Q_DEPTH))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue read while empty");

endmodule

### rtl/core/cdg_back.sv
// Back end: unpacks each queue entry into its results, one per beat,
// through a single output register. Uses cdg_pkg.
module cdg_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cdg_pkg::q_entry_t    head,
  input  cdg_pkg::q_stat_t     q_stat,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output cdg_pkg::result_t     out_res
);
  import cdg_pkg::*;

  localparam logic [2:0] PICK_A = 3'b001;
  localparam logic [2:0] PICK_B = 3'b010;
  localparam logic [2:0] PICK_C = 3'b100;

  logic [2:0] sent_r, pend, pick;
  logic       load, pick_last;
  logic       out_valid_r;
  result_t    out_res_r, res;

  assign pend = {head.has_c, head.has_b, head.has_a} & ~sent_r;

  always_comb begin
    if (pend[0])      pick = PICK_A;
    else if (pend[1]) pick = PICK_B;
    else              pick = PICK_C;
  end

  assign pick_last = ((pend & ~pick) == '0);
  assign load      = q_stat.not_empty && (!out_valid_r || out_tready);
  assign pop       = load && pick_last;

  always_comb begin
    res      = '0;
    res.row  = head.row;
    res.col  = head.col;
    res.last = pick_last;
    case (pick)
      PICK_A: begin
        res.row = head.row - ROW_W'(1);
        res.gx  = head.gx_a;
        res.gy  = head.gy_a;
      end
      PICK_B: begin
        res.col = head.col - COL_W'(1);
        res.gx  = head.gx_b;
      end
      PICK_C: begin
        res.eof = 1'b1;
      end
      default: begin
        res.gx = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) sent_r <= pick_last ? '0 : (sent_r | pick);
      if (load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.eof |-> out_res_r.last)
    else $error("end-of-frame result not last of its pixel");

  a_sent_subset: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.not_empty |-> pend != '0)
    else $error("queue head has no result left to send");

endmodule

### rtl/core/central_difference_gradient_unit.sv
// Top level of the central-difference gradient unit: configuration
// registers, beat packing, and the front / queue / back instances. Uses cdg_pkg.
//
//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------------------
//  in_     | slave     | one RGB pixel, raster order
//  out_    | master    | one gradient result, tlast closes a pixel's results
//  cfg_    | slave     | register write: 0 image_width, 1 image_height
//
// One pixel is taken per cycle while the queue has room; the line stores are read once per
// pixel, on intake, and the difference stage follows in the next cycle. A pixel gives 0 to
// 3 results and the output register sends one per cycle while out_tready is high, so rows
// before the last run at one pixel per cycle; the last row runs slower, since its pixels
// can give two results each.
// Reset is synchronous (rst_n low) and needs no clearing pass of the stores.
// A stall on out_ fills the four-entry queue, then in_tready drops.
module central_difference_gradient_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: pixel_blue[7:0], pixel_green[15:8], pixel_red[23:16]
  input  logic [cdg_pkg::PIX_W-1:0]         in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: out_row[11:0], out_col[22:12], grad_x_blue[31:23], grad_x_green[40:32],
  //        grad_x_red[49:41], grad_y_blue[58:50], grad_y_green[67:59],
  //        grad_y_red[76:68], zero fill[79:77]
  output logic [cdg_pkg::OUT_DATA_W-1:0]    out_tdata,
  // tuser: end_of_frame[0]
  output logic                              out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cdg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cdg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cdg_pkg::*;

  logic [WID_W-1:0] image_width_r;
  logic [HGT_W-1:0] image_height_r;
  logic             restart;
  logic             cfg_acc;
  dim_cfg_t         dim;
  q_entry_t         push_entry, head;
  q_stat_t          q_stat;
  logic             q_push, q_pop;
  result_t          res;

  // Configuration is always taken; a write restarts the frame
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WID_W'(RESET_WIDTH);
      image_height_r <= HGT_W'(RESET_HEIGHT);
    end else if (cfg_acc) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= clamp_width(cfg_data[CFG_WIDTH_BITS-1:0]);
        REG_IMAGE_HEIGHT: image_height_r <= clamp_height(cfg_data[CFG_HEIGHT_BITS-1:0]);
        default: begin
          image_width_r <= image_width_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_IMAGE_WIDTH:  restart = cfg_acc;
      REG_IMAGE_HEIGHT: restart = cfg_acc;
      default:          restart = 1'b0;
    endcase
  end

  assign dim.image_width  = image_width_r;
  assign dim.image_height = image_height_r;
  assign dim.restart      = restart;

  cdg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .dim       (dim),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_pix    (pix_t'(in_tdata)),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  cdg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .stat       (q_stat)
  );

  cdg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  // Pack the result beat, lowest field first
  assign out_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0),
                      res.gy.red, res.gy.green, res.gy.blue,
                      res.gx.red, res.gx.green, res.gx.blue,
                      res.col, res.row};
  assign out_tlast = res.last;
  assign out_tuser = res.eof;

endmodule
